@@ hw/rtl/mwc_pkg.sv @@
// Shared types and constants for the max-weight closure engine.
package mwc_pkg;

    localparam int CMD_W  = 2;
    localparam int NODE_W = 6;
    localparam int CAP_W  = 30;
    localparam int OUT_W  = 29;

    localparam logic [CAP_W-1:0] CAP_MAX    = 30'h3FFF_FFFF;
    localparam logic [CAP_W-1:0] GAIN_START = 30'd1000000000;

    localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

endpackage

@@ hw/rtl/max_weight_closure_maxflow.sv @@
// Max-weight closure by breadth-first max flow: stream ports and result register.
// Weight loads pass through read, update and sink-write states, edge loads are written
// while idle; compute first sets the edge capacities, then runs searches that pop nodes,
// scan neighbors and augment path hops, all on one sequencer sharing the store ports.
// After reset and after each result a clearing pass over all 2**(2*clog2(MAX_NODES+3))
// addresses (16384 by default) zeroes both stores; no word is taken meanwhile.
module max_weight_closure_maxflow #(
    parameter int MAX_NODES   = 62,
    parameter int WEIGHT_BITS = 24,
    localparam int IN_W = ((2 * mwc_pkg::NODE_W + mwc_pkg::CMD_W + WEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,   // cmd, node_a, node_b, weight
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // closure_value
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mwc_pkg::NODE_W-1:0] cfg_data
);

    localparam int A_LO = mwc_pkg::CMD_W;
    localparam int B_LO = A_LO + mwc_pkg::NODE_W;
    localparam int W_LO = B_LO + mwc_pkg::NODE_W;

    logic [mwc_pkg::NODE_W-1:0] node_count_reg;
    logic                       out_valid_reg;
    logic [mwc_pkg::OUT_W-1:0]  out_data_reg;
    mwc_pkg::req_t              req;
    logic                       res_valid, res_ready;
    logic [mwc_pkg::OUT_W-1:0]  res_value;

    assign req.cmd    = s_tdata[mwc_pkg::CMD_W-1:0];
    assign req.node_a = s_tdata[A_LO +: mwc_pkg::NODE_W];
    assign req.node_b = s_tdata[B_LO +: mwc_pkg::NODE_W];

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = 32'(out_data_reg);

    mwc_engine #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .req_weight (s_tdata[W_LO +: WEIGHT_BITS]),
        .node_count (node_count_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_value  (res_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= mwc_pkg::NODE_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                node_count_reg <= cfg_data;
            if (res_valid && res_ready)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res_value;
    end

endmodule

@@ hw/rtl/mwc_engine.sv @@
// Sequencer, stores and shared datapath for load, search and augment.
module mwc_engine #(
    parameter int MAX_NODES   = 62,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  mwc_pkg::req_t              req,
    input  logic [WEIGHT_BITS-1:0]     req_weight,
    input  logic [mwc_pkg::NODE_W-1:0] node_count,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [mwc_pkg::OUT_W-1:0]  res_value
);

    localparam int SLOTS = MAX_NODES + 3;
    localparam int NW    = $clog2(SLOTS);
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 2 ** AW;
    localparam int SD    = 2 ** NW;
    localparam int QW    = $clog2(SLOTS + 1);
    localparam int CW    = (NW > mwc_pkg::NODE_W) ? NW : mwc_pkg::NODE_W;
    localparam int MW    = (WEIGHT_BITS + 1 > mwc_pkg::CAP_W) ? WEIGHT_BITS + 1
                                                              : mwc_pkg::CAP_W;
    localparam int KW    = mwc_pkg::CAP_W;

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_WRD   = 16'h0004,
        S_WUPD  = 16'h0008,
        S_WSNK  = 16'h0010,
        S_PREP  = 16'h0020,
        S_PREPW = 16'h0040,
        S_BINIT = 16'h0080,
        S_POP   = 16'h0100,
        S_POPU  = 16'h0200,
        S_SCAN  = 16'h0400,
        S_EVAL  = 16'h0800,
        S_AUG   = 16'h1000,
        S_AUGR  = 16'h2000,
        S_AUGW  = 16'h4000,
        S_DONE  = 16'h8000
    } state_t;

    // stores
    logic [KW-1:0] cap_mem  [DEPTH];
    logic [KW-1:0] flow_mem [DEPTH];
    logic [KW-1:0] gain_mem [SD];
    logic [NW:0]   par_mem  [SD];
    logic [NW-1:0] q_mem    [SD];

    logic [KW-1:0] cap_rd_reg, flow_ra_reg, flow_rb_reg, gain_rd_reg;
    logic [NW:0]   par_rd_reg;
    logic [NW-1:0] q_rd_reg;

    logic          cap_we, flow_we, gain_we, gain_re, par_we, q_we;
    logic [AW-1:0] cap_wa, cap_ra, flow_wa, flow_ra, flow_rb;
    logic [KW-1:0] cap_wd, flow_wd, gain_wd;
    logic [NW-1:0] gain_wa, gain_ra, par_wa, par_ra, q_wa, q_ra;
    logic [NW:0]   par_wd;
    logic [NW-1:0] q_wd;

    state_t        state_reg, state_next;
    logic [NW-1:0] n_reg, n_next, a_reg, a_next, b_reg, b_next;
    logic [KW-1:0] mag_reg, mag_next, pt_reg, pt_next, tf_reg, tf_next;
    logic          neg_reg, neg_next;
    logic [NW-1:0] i_reg, i_next, j_reg, j_next, u_reg, u_next, v_reg, v_next;
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next, guard_reg, guard_next;
    logic [KW-1:0] gaug_reg, gaug_next;
    logic [AW-1:0] aug_addr_reg, aug_addr_next, clr_reg, clr_next;
    logic [SD-1:0] vis_reg, vis_next;

    logic [NW-1:0] src, snk, top_idx, lu;
    logic [CW-1:0] nc_w, n_w, a_w, b_w;
    logic [NW-1:0] n_new;
    logic          a_ok, b_ok, w_neg, cap_gt, take, lback;
    logic signed [WEIGHT_BITS:0] w_ext;
    logic [WEIGHT_BITS:0] w_abs;
    logic [MW-1:0] mag_w;
    logic [KW-1:0] mag_c, ptc, pt_pos, g_sel, new_g, tf_sat;
    logic [KW:0]   pt_sum, tf_sum;
    logic [QW-1:0] tail_p1;

    always_ff @(posedge clk)
    begin
        if (cap_we)
            cap_mem[cap_wa] <= cap_wd;
        cap_rd_reg <= cap_mem[cap_ra];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we)
            flow_mem[flow_wa] <= flow_wd;
        flow_ra_reg <= flow_mem[flow_ra];
        flow_rb_reg <= flow_mem[flow_rb];
    end

    always_ff @(posedge clk)
    begin
        if (gain_we)
            gain_mem[gain_wa] <= gain_wd;
        if (gain_re)
            gain_rd_reg <= gain_mem[gain_ra];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_wa] <= par_wd;
        par_rd_reg <= par_mem[par_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
        q_rd_reg <= q_mem[q_ra];
    end

    // command decode helpers
    assign nc_w  = CW'(node_count);
    assign n_w   = (nc_w == '0) ? CW'(1) : ((nc_w > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_w);
    assign n_new = n_w[NW-1:0];
    assign a_w   = CW'(req.node_a);
    assign b_w   = CW'(req.node_b);
    assign a_ok  = (a_w != '0) && (a_w <= n_w);
    assign b_ok  = (b_w != '0) && (b_w <= n_w);
    assign w_neg = req_weight[WEIGHT_BITS-1];
    assign w_ext = {req_weight[WEIGHT_BITS-1], req_weight};
    assign w_abs = w_neg ? unsigned'(-w_ext) : unsigned'(w_ext);
    assign mag_w = MW'(w_abs);
    assign mag_c = (mag_w > MW'(mwc_pkg::CAP_MAX)) ? mwc_pkg::CAP_MAX : mag_w[KW-1:0];

    assign src     = n_reg + NW'(1);
    assign snk     = n_reg + NW'(2);
    assign top_idx = snk;

    // weight update: drop old profit, add new positive one with saturation
    assign ptc    = (cap_rd_reg > pt_reg) ? '0 : pt_reg - cap_rd_reg;
    assign pt_sum = {1'b0, ptc} + {1'b0, mag_reg};
    assign pt_pos = (pt_sum > {1'b0, mwc_pkg::CAP_MAX - KW'(1)})
                    ? mwc_pkg::CAP_MAX - KW'(1) : pt_sum[KW-1:0];

    // residual test for one neighbor
    assign cap_gt = cap_rd_reg > flow_ra_reg;
    assign take   = !vis_reg[i_reg] && (cap_gt || (flow_rb_reg != '0));
    assign g_sel  = cap_gt ? cap_rd_reg - flow_ra_reg : flow_rb_reg;
    assign new_g  = (gain_rd_reg < g_sel) ? gain_rd_reg : g_sel;
    assign tf_sum = {1'b0, tf_reg} + {1'b0, new_g};
    assign tf_sat = (tf_sum > {1'b0, mwc_pkg::CAP_MAX}) ? mwc_pkg::CAP_MAX : tf_sum[KW-1:0];
    assign tail_p1 = tail_reg + QW'(1);

    assign lu    = par_rd_reg[NW-1:0];
    assign lback = par_rd_reg[NW];

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_value = (pt_reg > tf_reg) ? mwc_pkg::OUT_W'(pt_reg - tf_reg) : '0;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        pt_next       = pt_reg;
        tf_next       = tf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        guard_next    = guard_reg;
        gaug_next     = gaug_reg;
        aug_addr_next = aug_addr_reg;
        clr_next      = clr_reg;
        vis_next      = vis_reg;

        cap_we  = 1'b0;
        cap_wa  = {a_reg, b_reg};
        cap_wd  = '0;
        cap_ra  = {u_reg, i_reg};
        flow_we = 1'b0;
        flow_wa = aug_addr_reg;
        flow_wd = '0;
        flow_ra = {u_reg, i_reg};
        flow_rb = {i_reg, u_reg};
        gain_we = 1'b0;
        gain_wa = i_reg;
        gain_wd = new_g;
        gain_re = 1'b0;
        gain_ra = q_rd_reg;
        par_we  = 1'b0;
        par_wa  = i_reg;
        par_wd  = {!cap_gt, u_reg};
        par_ra  = v_reg;
        q_we    = 1'b0;
        q_wa    = tail_p1[NW-1:0];
        q_wd    = i_reg;
        q_ra    = head_reg[NW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                cap_we   = 1'b1;
                cap_wa   = clr_reg;
                flow_we  = 1'b1;
                flow_wa  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    n_next   = n_new;
                    a_next   = a_w[NW-1:0];
                    b_next   = b_w[NW-1:0];
                    mag_next = mag_c;
                    neg_next = w_neg;
                    case (req.cmd)
                        mwc_pkg::CMD_WEIGHT:
                            if (a_ok)
                                state_next = S_WRD;
                        mwc_pkg::CMD_EDGE:
                            if (a_ok && b_ok)
                            begin
                                cap_we = 1'b1;
                                cap_wa = {a_w[NW-1:0], b_w[NW-1:0]};
                                cap_wd = KW'(1);
                            end
                        mwc_pkg::CMD_COMPUTE:
                        begin
                            i_next     = NW'(1);
                            j_next     = NW'(1);
                            state_next = S_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            S_WRD:
            begin
                cap_ra     = {src, a_reg};
                state_next = S_WUPD;
            end
            S_WUPD:
            begin
                cap_we     = 1'b1;
                cap_wa     = {a_reg, snk};
                cap_wd     = neg_reg ? mag_reg : '0;
                pt_next    = neg_reg ? ptc : pt_pos;
                state_next = S_WSNK;
            end
            S_WSNK:
            begin
                cap_we     = 1'b1;
                cap_wa     = {src, a_reg};
                cap_wd     = neg_reg ? '0 : mag_reg;
                state_next = S_IDLE;
            end
            S_PREP:
            begin
                cap_ra     = {i_reg, j_reg};
                state_next = S_PREPW;
            end
            S_PREPW:
            begin
                cap_we = (cap_rd_reg != '0);
                cap_wa = {i_reg, j_reg};
                cap_wd = pt_reg + KW'(1);
                state_next = S_PREP;
                if (j_reg == n_reg)
                begin
                    j_next = NW'(1);
                    i_next = i_reg + NW'(1);
                    if (i_reg == n_reg)
                        state_next = S_BINIT;
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                end
            end
            S_BINIT:
            begin
                vis_next      = '0;
                vis_next[src] = 1'b1;
                q_we          = 1'b1;
                q_wa          = '0;
                q_wd          = src;
                gain_we       = 1'b1;
                gain_wa       = src;
                gain_wd       = mwc_pkg::GAIN_START;
                head_next     = '0;
                tail_next     = '0;
                state_next    = S_POP;
            end
            S_POP:
            begin
                if ((head_reg <= tail_reg) && (head_reg < QW'(SLOTS)))
                begin
                    head_next  = head_reg + QW'(1);
                    state_next = S_POPU;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POPU:
            begin
                u_next     = q_rd_reg;
                gain_re    = 1'b1;
                i_next     = NW'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_SCAN;
                if (i_reg == top_idx)
                    state_next = S_POP;
                i_next = i_reg + NW'(1);
                if (take)
                begin
                    gain_we = 1'b1;
                    par_we  = 1'b1;
                    if (i_reg == snk)
                    begin
                        tf_next    = tf_sat;
                        gaug_next  = new_g;
                        v_next     = snk;
                        guard_next = '0;
                        state_next = S_AUG;
                    end
                    else if (tail_p1 < QW'(SLOTS))
                    begin
                        q_we            = 1'b1;
                        tail_next       = tail_p1;
                        vis_next[i_reg] = 1'b1;
                    end
                end
            end
            S_AUG:
            begin
                if ((v_reg == src) || (guard_reg >= QW'(SLOTS)))
                    state_next = S_BINIT;
                else
                    state_next = S_AUGR;
            end
            S_AUGR:
            begin
                aug_addr_next = lback ? {v_reg, lu} : {lu, v_reg};
                flow_ra       = aug_addr_next;
                v_next        = lu;
                state_next    = S_AUGW;
            end
            S_AUGW:
            begin
                flow_we    = 1'b1;
                flow_wd    = (aug_addr_reg[AW-1 -: NW] == v_reg) ? flow_ra_reg + gaug_reg
                                                                 : flow_ra_reg - gaug_reg;
                guard_next = guard_reg + QW'(1);
                state_next = S_AUG;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    pt_next    = '0;
                    tf_next    = '0;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pt_reg    <= '0;
            tf_reg    <= '0;
            vis_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            guard_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pt_reg    <= pt_next;
            tf_reg    <= tf_next;
            vis_reg   <= vis_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            guard_reg <= guard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        gaug_reg     <= gaug_next;
        aug_addr_reg <= aug_addr_next;
    end

endmodule
